[rtl/core/ppurp_pkg.sv]
package ppurp_pkg;

	localparam int unsigned VRAM_DEPTH = 16384;
	localparam int unsigned VRAM_AW    = $clog2(VRAM_DEPTH);

	localparam logic [VRAM_AW-1:0] VRAM_STEP_ROW = VRAM_AW'(32);
	localparam logic [VRAM_AW-1:0] VRAM_STEP_COL = VRAM_AW'(1);

	localparam logic [7:0] STATUS_RESET = 8'hA0;

	typedef enum logic [1:0] {
		FUNC_WRITE  = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_VBLANK = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic deliver;
	} cmd_t;

endpackage

[rtl/core/ppurp_ram.sv]
module ppurp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/ppurp_ctrl.sv]
module ppurp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output ppurp_pkg::cmd_t  cmd
);

	ppurp_pkg::state_t state_q;
	ppurp_pkg::state_t state_d;
	logic              accept;

	assign busy   = (state_q == ppurp_pkg::ST_EXEC);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppurp_pkg::ST_IDLE: begin
				if (accept) state_d = ppurp_pkg::ST_EXEC;
			end
			ppurp_pkg::ST_EXEC: begin
				state_d = ppurp_pkg::ST_DONE;
			end
			ppurp_pkg::ST_DONE: begin
				state_d = accept ? ppurp_pkg::ST_EXEC : ppurp_pkg::ST_IDLE;
			end
			default: begin
				state_d = ppurp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppurp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.capture = accept;
	assign cmd.exec    = busy;
	assign cmd.deliver = (state_q == ppurp_pkg::ST_DONE);

endmodule

[rtl/core/ppurp_dp.sv]
module ppurp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ppurp_pkg::cmd_t               cmd,
	input  logic [1:0]                    func,
	input  logic [2:0]                    reg_select,
	input  logic [7:0]                    write_data,
	output logic [7:0]                    read_data,
	output logic                          nmi_request,
	output logic [1:0]                    nametable_select,
	output logic                          scroll_strobe,
	output logic                          scroll_second,
	output logic [ppurp_pkg::VRAM_AW-1:0] vram_pointer
);

	logic [1:0] func_q;
	logic [2:0] reg_q;
	logic [7:0] data_q;

	logic [7:0]                    regs_q [8];
	logic                          fwp_q;
	logic [7:0]                    latch_q;
	logic [ppurp_pkg::VRAM_AW-1:0] vaddr_q;

	logic [7:0] rd_q;
	logic       nmi_q;
	logic       strobe_q;
	logic       second_q;
	logic       from_ram_q;

	logic       is_wr;
	logic       is_rd;
	logic       ram_we;
	logic       ram_re;
	logic [7:0] ram_rdata;
	logic [7:0] ctrl;
	logic [7:0] status;

	assign ctrl   = regs_q[ppurp_pkg::REG_CTRL];
	assign status = regs_q[ppurp_pkg::REG_STATUS];
	assign is_wr  = cmd.exec && (func_q == ppurp_pkg::FUNC_WRITE);
	assign is_rd  = cmd.exec && (func_q == ppurp_pkg::FUNC_READ);
	assign ram_we = is_wr && (reg_q == ppurp_pkg::REG_DATA);
	assign ram_re = is_rd && (reg_q == ppurp_pkg::REG_DATA);

	ppurp_ram #(
		.WIDTH(8),
		.DEPTH(ppurp_pkg::VRAM_DEPTH)
	) u_vram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vaddr_q),
		.wdata (data_q),
		.re    (ram_re),
		.raddr (vaddr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			reg_q  <= reg_select;
			data_q <= write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				regs_q[i] <= '0;
			end
			regs_q[ppurp_pkg::REG_STATUS] <= ppurp_pkg::STATUS_RESET;
			fwp_q      <= 1'b1;
			latch_q    <= '0;
			vaddr_q    <= '0;
			rd_q       <= '0;
			nmi_q      <= 1'b0;
			strobe_q   <= 1'b0;
			second_q   <= 1'b0;
			from_ram_q <= 1'b0;
		end else if (cmd.exec) begin
			rd_q       <= '0;
			nmi_q      <= 1'b0;
			strobe_q   <= 1'b0;
			second_q   <= 1'b0;
			from_ram_q <= 1'b0;
			case (func_q)
				ppurp_pkg::FUNC_WRITE: begin
					regs_q[reg_q] <= data_q;
					case (reg_q)
						ppurp_pkg::REG_CTRL: begin
							nmi_q <= data_q[7] && !ctrl[7] && status[7];
						end
						ppurp_pkg::REG_SCROLL: begin
							strobe_q <= 1'b1;
							second_q <= !fwp_q;
							fwp_q    <= !fwp_q;
						end
						ppurp_pkg::REG_ADDR: begin
							if (fwp_q) begin
								latch_q <= data_q;
							end else begin
								vaddr_q <= {latch_q[ppurp_pkg::VRAM_AW-9:0], data_q};
								regs_q[ppurp_pkg::REG_CTRL] <= {ctrl[7:2], latch_q[3:2]};
							end
							fwp_q <= !fwp_q;
						end
						ppurp_pkg::REG_DATA: begin
							vaddr_q <= vaddr_q + (ctrl[2] ? ppurp_pkg::VRAM_STEP_ROW
								: ppurp_pkg::VRAM_STEP_COL);
						end
						default: begin
						end
					endcase
				end
				ppurp_pkg::FUNC_READ: begin
					if (reg_q == ppurp_pkg::REG_DATA) begin
						from_ram_q <= 1'b1;
					end else begin
						rd_q <= regs_q[reg_q];
						if (reg_q == ppurp_pkg::REG_STATUS) begin
							regs_q[ppurp_pkg::REG_STATUS] <= {1'b0, status[6:0]};
							fwp_q <= 1'b1;
						end
					end
				end
				ppurp_pkg::FUNC_VBLANK: begin
					regs_q[ppurp_pkg::REG_STATUS] <= {1'b1, status[6:0]};
					nmi_q <= ctrl[7];
				end
				default: begin
				end
			endcase
		end
	end

	// read, nmi and scroll result fields are only meaningful while done is high
	assign read_data        = (cmd.deliver && from_ram_q) ? ram_rdata : rd_q;
	assign nmi_request      = nmi_q;
	assign nametable_select = ctrl[1:0];
	assign scroll_strobe    = strobe_q;
	assign scroll_second    = second_q;
	assign vram_pointer     = vaddr_q;

endmodule

[rtl/core/ppu_cpu_register_port_core.sv]
// CPU register port of the video chip. Pulse start with func, reg_select and
// write_data while busy is low; the beat is taken at that edge. The next edge
// raises done for exactly one cycle with the result fields, so the result
// is taken at the edge that ends the done cycle; there is no way to hold it
// off, so sample it then. busy is high only in the cycle after a beat is
// taken, so a new beat may be offered in the same cycle as done, but not
// while busy is high. Register 7 reads of never-written VRAM locations
// return undefined data.
module ppu_cpu_register_port_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [2:0]  reg_select,
	input  logic [7:0]  write_data,
	output logic        done,
	output logic [7:0]  read_data,
	output logic        nmi_request,
	output logic [1:0]  nametable_select,
	output logic        scroll_strobe,
	output logic        scroll_second,
	output logic [13:0] vram_pointer
);

	ppurp_pkg::cmd_t cmd;

	ppurp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	ppurp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.func             (func),
		.reg_select       (reg_select),
		.write_data       (write_data),
		.read_data        (read_data),
		.nmi_request      (nmi_request),
		.nametable_select (nametable_select),
		.scroll_strobe    (scroll_strobe),
		.scroll_second    (scroll_second),
		.vram_pointer     (vram_pointer)
	);

	assign done = cmd.deliver;

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a preceding execute cycle");

	a_exec_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("execute lasted more than one cycle");

	a_scroll_no_nmi: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scroll_strobe) |-> !nmi_request)
		else $error("scroll beat raised an NMI");

	a_second_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !scroll_strobe) |-> !scroll_second)
		else $error("scroll_second without scroll strobe");

endmodule
